// ===== rtl/mvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  // table geometry and field widths
  localparam int CAPACITY_DEF = 64;
  localparam int OP_W         = 2;
  localparam int KEY_W        = 32;
  localparam int OUT_CNT_W    = 7;
  localparam int COUNT_MAX    = 127;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ALTER  = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  // word travelling down the chain of cells
  typedef struct packed {
    logic                    valid;
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] repl;
    logic                    ok;
    logic                    hit;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/mvt_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mvt_cmd_if;
  import mvt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] key_value;
  logic signed [KEY_W-1:0] new_value;

  modport source (output valid, output operation, output key_value, output new_value,
                  input ready);
  modport sink   (input valid, input operation, input key_value, input new_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/mvt_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mvt_res_if;
  import mvt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 insert_ok;
  logic [OUT_CNT_W-1:0] match_count;
  logic                 found;

  modport source (output valid, output insert_ok, output match_count, output found,
                  input ready);
  modport sink   (input valid, input insert_ok, input match_count, input found,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/multiset_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Multiset value table: a bounded table of signed 32-bit values, duplicates allowed.
// Command channel (cmd) carries operation, key_value and new_value: insert, remove
// all matching, alter all matching, or search. Result channel (res) returns one word
// per command: insert_ok, match_count (saturating at 127) and found.
// The table is a chain of CAPACITY cells, each holding one entry. A command word
// walks the chain one cell per cycle unless the chain is held; each cell compares
// and updates its own entry and passes the running count and flags on. Insert
// takes the lowest free entry. A command's word is registered in each cell in turn,
// and its result is taken from the last cell's register.
// Throughput: one command per cycle when the chain is not held; several commands are
// in the chain at once, and they see the table in the order they were accepted.
// The last cell's register is the output register. When the receiver stalls, the
// whole chain holds and cmd.ready goes low until the waiting result is taken.
// Reset (rst, synchronous) clears every entry's valid mark and empties the chain;
// cmd.ready is low during reset, and the table is empty and ready in the first
// cycle after reset.
module multiset_value_table #(
  parameter int CAPACITY = mvt_pkg::CAPACITY_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  mvt_cmd_if.sink   cmd,
  mvt_res_if.source res
);
  import mvt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SAT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  tok_t             tok [CAPACITY+1];
  logic [CNT_W-1:0] cnt [CAPACITY+1];
  logic             advance;
  logic [SAT_W-1:0] cnt_ext;

  // chain moves whenever the output register is free or being emptied
  assign advance   = !tok[CAPACITY].valid || res.ready;
  assign cmd.ready = advance && !rst;

  // incoming command word
  always_comb begin
    tok[0].valid = cmd.valid;
    tok[0].op    = op_t'(cmd.operation);
    tok[0].key   = cmd.key_value;
    tok[0].repl  = cmd.new_value;
    tok[0].ok    = 1'b0;
    tok[0].hit   = 1'b0;
  end
  assign cnt[0] = '0;

  // chain of entry cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    mvt_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[k]),
      .cnt_in  (cnt[k]),
      .tok_out (tok[k+1]),
      .cnt_out (cnt[k+1])
    );
  end

  // result word from the last cell
  assign cnt_ext         = SAT_W'(cnt[CAPACITY]);
  assign res.valid       = tok[CAPACITY].valid;
  assign res.insert_ok   = tok[CAPACITY].ok;
  assign res.found       = tok[CAPACITY].hit;
  assign res.match_count = (cnt_ext > SAT_W'(COUNT_MAX)) ? OUT_CNT_W'(COUNT_MAX)
                                                         : OUT_CNT_W'(cnt_ext);

endmodule

`default_nettype wire

// ===== rtl/mvt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_cell #(
  parameter int CNT_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire mvt_pkg::tok_t     tok_in,
  input  wire logic [CNT_W-1:0]  cnt_in,
  output mvt_pkg::tok_t          tok_out,
  output logic      [CNT_W-1:0]  cnt_out
);
  import mvt_pkg::*;

  // one table entry
  logic                    entry_valid;
  logic signed [KEY_W-1:0] entry_value;

  logic                    entry_valid_next;
  logic signed [KEY_W-1:0] entry_value_next;
  tok_t                    tok_next;
  logic [CNT_W-1:0]        cnt_next;
  logic                    match;

  assign match = entry_valid && (entry_value == tok_in.key);

  // apply the passing word to this entry
  always_comb begin
    entry_valid_next = entry_valid;
    entry_value_next = entry_value;
    tok_next         = tok_in;
    cnt_next         = cnt_in;
    if (tok_in.valid) begin
      unique case (tok_in.op)
        OP_INSERT: begin
          if (!entry_valid && !tok_in.ok) begin
            entry_valid_next = 1'b1;
            entry_value_next = tok_in.key;
            tok_next.ok      = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (match) begin
            entry_valid_next = 1'b0;
            cnt_next         = cnt_in + CNT_W'(1);
          end
        end
        OP_ALTER: begin
          if (match) begin
            entry_value_next = tok_in.repl;
            cnt_next         = cnt_in + CNT_W'(1);
          end
        end
        OP_SEARCH: begin
          if (match) begin
            tok_next.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entry and word registers; only the valid marks are cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      entry_valid <= entry_valid_next;
      entry_value <= entry_value_next;
      tok_out     <= tok_next;
      cnt_out     <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/multiset_value_table_test.sv =====
`timescale 1ns / 1ps

module multiset_value_table_test;
  import mvt_pkg::*;

  localparam int SLOTS        = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_AT     = 1200;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int MAX_GAP      = 17;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // kinds of random segment
  localparam int SEG_FILL  = 0;
  localparam int SEG_DRAIN = 1;
  localparam int SEG_MIXED = 2;
  localparam int SEG_NOISE = 3;

  typedef struct {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] repl;
    bit                      drain_first;
  } cmd_word_t;

  typedef struct {
    logic                 insert_ok;
    logic [OUT_CNT_W-1:0] match_count;
    logic                 found;
  } res_word_t;

  logic clk;
  logic rst;

  mvt_cmd_if cmd_bus ();
  mvt_res_if res_bus ();

  multiset_value_table #(.CAPACITY(SLOTS)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_val [SLOTS];
  bit               shadow_used [SLOTS];

  cmd_word_t pending [$];
  res_word_t due_results [int];
  cmd_word_t cur_cmd;
  int        sent_n;
  int        cmds_taken;
  int        results_seen;
  int        errors;
  int        cycles;

  int send_gap;
  bit send_idle;
  int take_gap;
  bit take_idle;
  int hold_left;
  bit hold_done;

  logic signed [KEY_W-1:0] pool_vals [8];
  int                      pool_n;

  // apply one command word to the shadow table and return its result word
  function automatic res_word_t apply_command(cmd_word_t c);
    res_word_t r;
    int        n;
    r = '{insert_ok: 1'b0, match_count: '0, found: 1'b0};
    n = 0;
    case (c.op)
      OP_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow_used[i]) begin
            shadow_val[i]  = c.key;
            shadow_used[i] = 1'b1;
            r.insert_ok    = 1'b1;
            break;
          end
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_used[i] && shadow_val[i] == c.key) begin
            shadow_used[i] = 1'b0;
            n++;
          end
        end
      end
      OP_ALTER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_used[i] && shadow_val[i] == c.key) begin
            shadow_val[i] = c.repl;
            n++;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_used[i] && shadow_val[i] == c.key) r.found = 1'b1;
        end
      end
    endcase
    r.match_count = (n > COUNT_MAX) ? OUT_CNT_W'(COUNT_MAX) : OUT_CNT_W'(n);
    return r;
  endfunction

  task automatic queue_cmd(op_t op, logic signed [KEY_W-1:0] key,
                           logic signed [KEY_W-1:0] repl, bit drain_first);
    cmd_word_t c;
    c.op          = op;
    c.key         = key;
    c.repl        = repl;
    c.drain_first = drain_first;
    pending.push_back(c);
  endtask

  function automatic logic signed [KEY_W-1:0] pool_value();
    if ($urandom_range(0, 99) < 85) return pool_vals[$urandom_range(0, pool_n - 1)];
    return $urandom;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // command driver
  always @(posedge clk) begin : drive
    logic offer;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      offer = cmd_bus.valid;
      if (cmd_bus.valid && cmd_bus.ready) begin
        due_results[sent_n] = apply_command(cur_cmd);
        sent_n++;
        cmds_taken <= sent_n;
        offer = 1'b0;
        if ($urandom_range(0, 99) == 0) send_idle = !send_idle;
        send_gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0 &&
                     (!pending[0].drain_first || results_seen == sent_n)) begin
          cur_cmd = pending.pop_front();
          cmd_bus.operation <= cur_cmd.op;
          cmd_bus.key_value <= cur_cmd.key;
          cmd_bus.new_value <= cur_cmd.repl;
          offer = 1'b1;
        end
      end
      cmd_bus.valid <= offer;
    end
  end

  // one long receiver hold so the chain fills and the command side backs up
  always @(posedge clk) begin : hold
    if (!rst) begin
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : watch
    res_word_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (results_seen >= cmds_taken) begin
          $error("result word with no command outstanding");
          errors++;
        end else begin
          want = due_results[results_seen];
          due_results.delete(results_seen);
          if (res_bus.insert_ok !== want.insert_ok) begin
            $error("insert_ok: expected %0d, got %0d", want.insert_ok, res_bus.insert_ok);
            errors++;
          end
          if (res_bus.match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count,
                   res_bus.match_count);
            errors++;
          end
          if (res_bus.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, res_bus.found);
            errors++;
          end
        end
        results_seen <= results_seen + 1;
        if ($urandom_range(0, 99) == 0) take_idle = !take_idle;
        take_gap = take_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_left > 0 || (!hold_done && results_seen == HOLD_AT)) begin
        res_bus.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stim
    int                      mode;
    int                      seg_len;
    int                      r;
    int                      made;
    op_t                     op;
    logic signed [KEY_W-1:0] k;
    logic signed [KEY_W-1:0] v;

    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.operation = OP_SEARCH;
    cmd_bus.key_value = '0;
    cmd_bus.new_value = '0;
    res_bus.ready     = 1'b0;
    sent_n            = 0;
    cmds_taken        = 0;
    results_seen      = 0;
    errors            = 0;
    cycles            = 0;
    send_gap          = 0;
    send_idle         = 1'b1;
    take_gap          = 0;
    take_idle         = 1'b1;
    hold_left         = 0;
    hold_done         = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_val[i]  = '0;
      shadow_used[i] = 1'b0;
    end

    // operations on an empty table
    queue_cmd(OP_SEARCH, 32'sd0, 32'sd0, 1'b0);
    queue_cmd(OP_REMOVE, 32'sd0, 32'sd0, 1'b0);
    queue_cmd(OP_ALTER,  32'sd0, 32'sd1, 1'b0);
    // field extremes and duplicates
    queue_cmd(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    queue_cmd(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    queue_cmd(OP_INSERT, 32'sd0, 32'hffff_ffff, 1'b0);
    queue_cmd(OP_INSERT, 32'hffff_ffff, 32'sd0, 1'b0);
    queue_cmd(OP_INSERT, 32'h7fff_ffff, 32'sd0, 1'b0);
    queue_cmd(OP_INSERT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    queue_cmd(OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);
    queue_cmd(OP_SEARCH, 32'h8000_0000, 32'sd0, 1'b0);
    queue_cmd(OP_SEARCH, 32'h7fff_ffff, 32'sd0, 1'b0);
    queue_cmd(OP_SEARCH, 32'sd1, 32'sd0, 1'b0);
    // alter onto the same value keeps the entries but counts them
    queue_cmd(OP_ALTER,  32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    queue_cmd(OP_ALTER,  32'sd0, 32'h8000_0000, 1'b0);
    queue_cmd(OP_REMOVE, 32'h7fff_ffff, 32'sd0, 1'b0);
    queue_cmd(OP_SEARCH, 32'h7fff_ffff, 32'sd0, 1'b0);
    queue_cmd(OP_REMOVE, 32'h8000_0000, 32'sd0, 1'b0);
    queue_cmd(OP_ALTER,  32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    queue_cmd(OP_REMOVE, 32'h5555_5555, 32'sd0, 1'b0);
    queue_cmd(OP_SEARCH, 32'hffff_ffff, 32'sd0, 1'b0);
    queue_cmd(OP_INSERT, 32'sd0, 32'sd0, 1'b0);

    // random segments: fill bursts reach a full table, small pools give big counts
    made = 0;
    while (made < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      mode = (r < 4) ? SEG_FILL : (r < 7) ? SEG_DRAIN : (r < 9) ? SEG_MIXED : SEG_NOISE;
      seg_len = $urandom_range(40, 120);
      pool_n = $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 5))
          0:       pool_vals[i] = 32'h8000_0000;
          1:       pool_vals[i] = 32'h7fff_ffff;
          2:       pool_vals[i] = $urandom_range(0, 3);
          3:       pool_vals[i] = 32'hffff_ffff;
          default: pool_vals[i] = $urandom;
        endcase
      end
      for (int j = 0; j < seg_len && made < RANDOM_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        case (mode)
          SEG_FILL:
            op = (r < 70) ? OP_INSERT : (r < 85) ? OP_SEARCH : (r < 95) ? OP_ALTER : OP_REMOVE;
          SEG_DRAIN:
            op = (r < 45) ? OP_REMOVE : (r < 70) ? OP_INSERT : (r < 85) ? OP_ALTER : OP_SEARCH;
          default:
            op = op_t'($urandom_range(0, 3));
        endcase
        if (mode == SEG_NOISE) begin
          k = $urandom;
          v = $urandom;
        end else begin
          k = pool_value();
          v = pool_value();
        end
        queue_cmd(op, k, v, made == DRAIN_AT);
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (pending.size() == 0 && !cmd_bus.valid && results_seen == cmds_taken);
    repeat (SLOTS + 32) @(posedge clk);
    if (errors == 0 && results_seen == cmds_taken) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
